// ===== hdl/mts_pkg.sv =====
package mts_pkg;

   localparam int CHANNELS_DEF = 8;

   localparam logic [1:0] OP_SET     = 2'd0;
   localparam logic [1:0] OP_CONTROL = 2'd1;
   localparam logic [1:0] OP_PRESET  = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   localparam logic [3:0] ACT_START = 4'd1;

   localparam logic [2:0] MODE_BLINK      = 3'd2;
   localparam logic [2:0] MODE_SWEEP_DUTY = 3'd3;
   localparam logic [2:0] MODE_SWEEP_FREQ = 3'd4;

   localparam logic [1:0]  FREQ_KIND_RESET = 2'd1;
   localparam logic [15:0] DUTY_MAX        = 16'd100;
   localparam logic [14:0] STEP_MAX        = 15'h7FFF;
   localparam logic [14:0] DUTY_STEP_DEF   = 15'd1;
   localparam logic [15:0] DUTY_PERIOD_DEF = 16'd1;
   localparam logic [15:0] FREQ_DEF        = 16'd100;
   localparam logic [14:0] FREQ_STEP_DEF   = 15'd100;
   localparam logic [15:0] FREQ_PERIOD_DEF = 16'd50;
   localparam logic [15:0] VALUE_MAX       = 16'hFFFF;

   typedef struct packed {
      logic latch;
      logic apply;
      logic advance;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic eligible;
      logic slot_free;
      logic pending;
   } dp_status_type;

endpackage

// ===== hdl/mts_ctrl.sv =====
module mts_ctrl #(
   parameter int CHANNELS = mts_pkg::CHANNELS_DEF,
   parameter int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_operation,
   output logic                  req_ready,
   input  mts_pkg::dp_status_type status,
   output mts_pkg::ctl_cmd_type  cmd,
   output logic [IW-1:0]         idx
);
   import mts_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_APPLY = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;
   localparam logic [IW-1:0] IDX_LAST = IW'(CHANNELS - 1);

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_in    = '0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (req_operation == OP_TICK) ? ST_SCAN : ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            if (!status.eligible || !status.pending || status.slot_free) begin
               cmd.advance = status.eligible;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pending) begin
               state_in = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign idx = idx_ff;

endmodule

// ===== hdl/mts_datapath.sv =====
module mts_datapath #(
   parameter int CHANNELS = mts_pkg::CHANNELS_DEF,
   parameter int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_freq_kind_code,
   input  logic [1:0]             req_operation,
   input  logic [3:0]             req_channel,
   input  logic [1:0]             req_sweep_kind,
   input  logic [15:0]            req_start_value,
   input  logic [15:0]            req_stop_value,
   input  logic [15:0]            req_step_value,
   input  logic [15:0]            req_period_value,
   input  logic [3:0]             req_action_code,
   input  logic [2:0]             req_preset_mode,
   input  mts_pkg::ctl_cmd_type   cmd,
   input  logic [IW-1:0]          idx,
   output mts_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_out_channel,
   output logic                   rsp_is_frequency,
   output logic [15:0]            rsp_value,
   output logic                   rsp_last
);
   import mts_pkg::*;

   logic [1:0]  freq_kind_ff;
   logic [31:0] now_ff;

   logic [1:0]  op_ff;
   logic [3:0]  ch_ff;
   logic [1:0]  kind_ff;
   logic [15:0] a_ff, b_ff, stp_ff, per_ff;
   logic [3:0]  act_ff;
   logic [2:0]  mode_ff;

   logic        running_ff   [CHANNELS];
   logic        freq_ff      [CHANNELS];
   logic [15:0] start_ff     [CHANNELS];
   logic [15:0] stop_ff      [CHANNELS];
   logic [15:0] cur_ff       [CHANNELS];
   logic [14:0] step_ff      [CHANNELS];
   logic        down_ff      [CHANNELS];
   logic        idle_ff      [CHANNELS];
   logic [15:0] period_ff    [CHANNELS];
   logic [31:0] last_upd_ff  [CHANNELS];

   logic        pend_ff;
   logic [3:0]  pend_ch_ff;
   logic        pend_freq_ff;
   logic [15:0] pend_val_ff;

   logic        out_valid_ff;
   logic [3:0]  out_ch_ff;
   logic        out_freq_ff;
   logic [15:0] out_val_ff;
   logic        out_last_ff;

   logic [3:0]    ch_m1;
   logic          ch_ok;
   logic [IW-1:0] addr;
   logic [14:0]   step_clamp, step_duty, step_freq;
   logic [15:0]   period_duty, period_freq, freq_start;
   logic [19:0]   freq_x10;
   logic [15:0]   freq_stop;
   logic [31:0]   elapsed;
   logic signed [17:0] nxt, cur_s, stop_s, start_s;
   logic [15:0]   new_cur, new_out;
   logic          new_down, new_idle;
   logic          load_out;

   assign ch_m1 = ch_ff - 4'd1;
   assign ch_ok = (ch_ff != 4'd0) && (ch_ff <= 4'(CHANNELS));
   assign addr  = cmd.apply ? ch_m1[IW-1:0] : idx;

   assign step_clamp  = (stp_ff > {1'b0, STEP_MAX}) ? STEP_MAX : stp_ff[14:0];
   assign step_duty   = (stp_ff == 16'd0) ? DUTY_STEP_DEF : step_clamp;
   assign step_freq   = (stp_ff == 16'd0) ? FREQ_STEP_DEF : step_clamp;
   assign period_duty = (per_ff == 16'd0) ? DUTY_PERIOD_DEF : per_ff;
   assign period_freq = (per_ff == 16'd0) ? FREQ_PERIOD_DEF : per_ff;
   assign freq_start  = (a_ff == 16'd0) ? FREQ_DEF : a_ff;
   assign freq_x10    = {1'b0, freq_start, 3'b0} + {3'b0, freq_start, 1'b0};
   assign freq_stop   = (freq_x10 > {4'b0, VALUE_MAX}) ? VALUE_MAX : freq_x10[15:0];

   assign elapsed = now_ff - last_upd_ff[addr];
   assign status.eligible  = running_ff[addr] && (elapsed >= {16'b0, period_ff[addr]});
   assign status.slot_free = !out_valid_ff || rsp_ready;
   assign status.pending   = pend_ff;

   assign cur_s   = signed'({2'b0, cur_ff[addr]});
   assign stop_s  = signed'({2'b0, stop_ff[addr]});
   assign start_s = signed'({2'b0, start_ff[addr]});

   always_comb begin
      nxt = cur_s;
      if (!idle_ff[addr]) begin
         nxt = down_ff[addr] ? cur_s - signed'({3'b0, step_ff[addr]})
                             : cur_s + signed'({3'b0, step_ff[addr]});
      end
      new_down = down_ff[addr];
      new_idle = idle_ff[addr];
      new_cur  = nxt[15:0];
      if (nxt >= stop_s) begin
         new_cur  = stop_ff[addr];
         new_down = 1'b1;
         new_idle = 1'b0;
      end else if (nxt <= start_s) begin
         new_cur  = start_ff[addr];
         new_down = 1'b0;
         new_idle = 1'b0;
      end
      new_out = (!freq_ff[addr] && new_cur > DUTY_MAX) ? DUTY_MAX : new_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_kind_ff <= FREQ_KIND_RESET;
      end else if (csr_valid) begin
         freq_kind_ff <= csr_freq_kind_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_operation;
         ch_ff   <= req_channel;
         kind_ff <= req_sweep_kind;
         a_ff    <= req_start_value;
         b_ff    <= req_stop_value;
         stp_ff  <= req_step_value;
         per_ff  <= req_period_value;
         act_ff  <= req_action_code;
         mode_ff <= req_preset_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
         for (int k = 0; k < CHANNELS; k++) begin
            running_ff[k]  <= 1'b0;
            freq_ff[k]     <= 1'b0;
            start_ff[k]    <= '0;
            stop_ff[k]     <= '0;
            cur_ff[k]      <= '0;
            step_ff[k]     <= '0;
            down_ff[k]     <= 1'b0;
            idle_ff[k]     <= 1'b0;
            period_ff[k]   <= '0;
            last_upd_ff[k] <= '0;
         end
      end else begin
         if (cmd.latch && req_operation == OP_TICK) begin
            now_ff <= now_ff + 32'd1;
         end
         if (cmd.apply && ch_ok) begin
            case (op_ff)
               OP_SET: begin
                  freq_ff[addr]  <= (kind_ff == freq_kind_ff);
                  start_ff[addr] <= a_ff;
                  stop_ff[addr]  <= b_ff;
                  cur_ff[addr]   <= a_ff;
                  idle_ff[addr]  <= 1'b1;
               end
               OP_CONTROL: begin
                  step_ff[addr]   <= step_duty;
                  period_ff[addr] <= period_duty;
                  if (act_ff == ACT_START) begin
                     cur_ff[addr]      <= start_ff[addr];
                     down_ff[addr]     <= !(stop_ff[addr] >= start_ff[addr]);
                     idle_ff[addr]     <= 1'b0;
                     running_ff[addr]  <= 1'b1;
                     last_upd_ff[addr] <= now_ff;
                  end else begin
                     running_ff[addr] <= 1'b0;
                  end
               end
               OP_PRESET: begin
                  if (mode_ff <= MODE_BLINK) begin
                     running_ff[addr] <= 1'b0;
                  end else if (mode_ff == MODE_SWEEP_DUTY) begin
                     freq_ff[addr]     <= 1'b0;
                     start_ff[addr]    <= '0;
                     stop_ff[addr]     <= DUTY_MAX;
                     step_ff[addr]     <= step_duty;
                     period_ff[addr]   <= period_duty;
                     cur_ff[addr]      <= '0;
                     down_ff[addr]     <= 1'b0;
                     idle_ff[addr]     <= 1'b0;
                     running_ff[addr]  <= 1'b1;
                     last_upd_ff[addr] <= now_ff;
                  end else if (mode_ff == MODE_SWEEP_FREQ) begin
                     freq_ff[addr]     <= 1'b1;
                     start_ff[addr]    <= freq_start;
                     stop_ff[addr]     <= freq_stop;
                     step_ff[addr]     <= step_freq;
                     period_ff[addr]   <= period_freq;
                     cur_ff[addr]      <= freq_start;
                     down_ff[addr]     <= 1'b0;
                     idle_ff[addr]     <= 1'b0;
                     running_ff[addr]  <= 1'b1;
                     last_upd_ff[addr] <= now_ff;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.advance) begin
            last_upd_ff[addr] <= now_ff;
            cur_ff[addr]      <= new_cur;
            down_ff[addr]     <= new_down;
            idle_ff[addr]     <= new_idle;
         end
      end
   end

   // pending beat holds back one result so the final one can carry last
   assign load_out = (cmd.advance && pend_ff) || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.advance) begin
            pend_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_ff <= 1'b0;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         pend_ch_ff   <= 4'({1'b0, idx} + 5'd1);
         pend_freq_ff <= freq_ff[addr];
         pend_val_ff  <= new_out;
      end
      if (load_out) begin
         out_ch_ff   <= pend_ch_ff;
         out_freq_ff <= pend_freq_ff;
         out_val_ff  <= pend_val_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_channel  = out_ch_ff;
   assign rsp_is_frequency = out_freq_ff;
   assign rsp_value        = out_val_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ===== hdl/multichannel_triangle_sweep.sv =====
// Multichannel triangle sweep generator.
// req_ channel: one beat per operation (set, control, preset, tick). Set,
//   control and preset update one channel record and give no result; they
//   pass through the apply state and then return to idle.
// rsp_ channel: one beat per channel moved by a tick, in channel order;
//   rsp_last marks the final beat of that tick. A tick that moves no
//   channel gives no beat.
// A tick scans every channel record in turn: the controller visits one
//   channel record per cycle, unless the receiver stalls, through a single
//   read/update port, and one result is held back so last can be known.
//   Each result passes through the pending register to the output register.
// csr_ channel: writes the frequency kind code; always ready. Write only
//   while the block is idle.
// Reset clears all channel records, the millisecond counter and the output.
// If the receiver stalls, the scan waits on the output register and the
//   pending result; no beat is lost, and new requests wait until the tick
//   is done.
module multichannel_triangle_sweep #(
   parameter int CHANNELS = mts_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_freq_kind_code,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_channel,
   input  logic [1:0]  req_sweep_kind,
   input  logic [15:0] req_start_value,
   input  logic [15:0] req_stop_value,
   input  logic [15:0] req_step_value,
   input  logic [15:0] req_period_value,
   input  logic [3:0]  req_action_code,
   input  logic [2:0]  req_preset_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_out_channel,
   output logic        rsp_is_frequency,
   output logic [15:0] rsp_value,
   output logic        rsp_last
);
   import mts_pkg::*;

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic [IW-1:0] idx;

   assign csr_ready = 1'b1;

   mts_ctrl #(
      .CHANNELS (CHANNELS),
      .IW       (IW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd),
      .idx           (idx)
   );

   mts_datapath #(
      .CHANNELS (CHANNELS),
      .IW       (IW)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_freq_kind_code (csr_freq_kind_code),
      .req_operation      (req_operation),
      .req_channel        (req_channel),
      .req_sweep_kind     (req_sweep_kind),
      .req_start_value    (req_start_value),
      .req_stop_value     (req_stop_value),
      .req_step_value     (req_step_value),
      .req_period_value   (req_period_value),
      .req_action_code    (req_action_code),
      .req_preset_mode    (req_preset_mode),
      .cmd                (cmd),
      .idx                (idx),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_is_frequency   (rsp_is_frequency),
      .rsp_value          (rsp_value),
      .rsp_last           (rsp_last)
   );

endmodule
